/* sv/bpa_pkg.sv */
// Shared constants for the bitmap page allocator: defaults, field widths,
// operation, status and register codes, and the used-map word geometry.
// No dependencies.
`default_nettype none

package bpa_pkg;

	localparam int MAX_PAGES_DEF = 4096;
	localparam int PAGE_SIZE_DEF = 4096;
	localparam int ADDR_BITS_DEF = 48;

	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int MEMB_W     = 25;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 1;

	localparam int WORD_W   = 64;
	localparam int WORD_LOG = $clog2(WORD_W);

	localparam int MAP_ROUND     = 7;
	localparam int BYTE_BITS_LOG = 3;

	localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MEMORY_BYTES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd1;

endpackage

`default_nettype wire

/* sv/bpa_find_first.sv */
// Priority encoder that returns the lowest set bit of a vector.
// Used for the word-full flags and for the bits of one used-map word.
// No dependencies.
`default_nettype none

module bpa_find_first #(
	parameter int W = 64
) (
	input  wire logic [W-1:0]                       vec,
	output logic                                    found,
	output logic [((W > 1) ? $clog2(W) : 1)-1:0]    idx
);

	localparam int IW = (W > 1) ? $clog2(W) : 1;

	always_comb begin
		found = |vec;
		idx   = '0;
		for (int i = W - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IW'(i);
			end
		end
	end

endmodule

`default_nettype wire

/* sv/bitmap_page_allocator_unit.sv */
// Bitmap page allocator, top level: item handshake, configuration registers,
// used-map memory, init sweep and allocate/free sequencer.
// Depends on bpa_pkg and bpa_find_first.
// Items pass a decode state; an allocate that finds a page and a free that passes the address
// checks then read and modify a map word. Init writes the NWORDS map words (MAX_PAGES / 64
// rounded up), one 64-bit word per cycle through the single memory write port. Each item ends
// in a finish state that waits for a free output register; a new item is accepted only after it.
// Reset clears the counts, base, registers and handshake state; the map is undefined until the
// first init, and no clearing pass runs after reset. PAGE_SIZE must be a power of two, not checked.
`default_nettype none

module bitmap_page_allocator_unit #(
	parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
	parameter int PAGE_SIZE = bpa_pkg::PAGE_SIZE_DEF,
	parameter int ADDR_BITS = bpa_pkg::ADDR_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [bpa_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
	input  wire logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [bpa_pkg::OP_W-1:0]          opcode,
	input  wire logic [ADDR_BITS-1:0]              page_address,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [bpa_pkg::STATUS_W-1:0]           status,
	output logic [ADDR_BITS-1:0]                   alloc_address,
	output logic [$clog2(MAX_PAGES + 1)-1:0]       pages_free,
	output logic [$clog2(MAX_PAGES + 1)-1:0]       pages_total
);

	localparam int WORD_W    = bpa_pkg::WORD_W;
	localparam int WORD_LOG  = bpa_pkg::WORD_LOG;
	localparam int CNT_W     = $clog2(MAX_PAGES + 1);
	localparam int NWORDS    = (MAX_PAGES + WORD_W - 1) / WORD_W;
	localparam int WIDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int IDX_EXT_W = WIDX_W + WORD_LOG;
	localparam int XW        = IDX_EXT_W + 1;
	localparam int PS_LOG    = $clog2(PAGE_SIZE);
	localparam int MEMB_W    = bpa_pkg::MEMB_W;
	localparam int SUM_W     = CNT_W + PS_LOG + 1;
	localparam int CMP_W     = (ADDR_BITS > CNT_W) ? ADDR_BITS : CNT_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_INIT = 3'd2;
	localparam logic [2:0] S_READ = 3'd3;
	localparam logic [2:0] S_MOD  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]                      state_q;
	logic [MEMB_W-1:0]               mem_bytes_q;
	logic [bpa_pkg::CFG_DATA_W-1:0]  base_cfg_q;
	logic [ADDR_BITS-1:0]            base_q;
	logic [CNT_W-1:0]                total_q;
	logic [CNT_W-1:0]                free_q;
	logic [CNT_W-1:0]                map_q;
	logic [NWORDS-1:0]               full_q;
	logic [WIDX_W-1:0]               wcnt_q;
	logic [bpa_pkg::OP_W-1:0]        op_q;
	logic [ADDR_BITS-1:0]            addr_q;
	logic [IDX_EXT_W-1:0]            pg_q;
	logic [bpa_pkg::STATUS_W-1:0]    st_q;
	logic                            out_valid_q;
	logic [bpa_pkg::STATUS_W-1:0]    status_q;
	logic [ADDR_BITS-1:0]            alloc_address_q;
	logic [CNT_W-1:0]                pages_free_q;
	logic [CNT_W-1:0]                pages_total_q;

	logic [WORD_W-1:0]               mem [NWORDS];
	logic [WORD_W-1:0]               rdata_q;
	logic                            mem_we;
	logic [WIDX_W-1:0]               mem_waddr;
	logic [WORD_W-1:0]               mem_wdata;

	logic                            flag_found;
	logic [WIDX_W-1:0]               flag_idx;
	logic                            bit_found;
	logic [WORD_LOG-1:0]             bit_idx;

	logic [MEMB_W-1:0]               pages_raw;
	logic [CNT_W-1:0]                pages_sat;
	logic [CNT_W:0]                  map_bytes;
	logic [SUM_W-1:0]                map_sum;
	logic [SUM_W-1:0]                map_pg;
	logic [CNT_W-1:0]                map_pages;
	logic [ADDR_BITS-1:0]            free_off;
	logic [ADDR_BITS-1:0]            free_pidx;
	logic                            free_bad;
	logic [XW-1:0]                   sweep_base;
	logic [WORD_W-1:0]               sweep_word;
	logic [WORD_W-1:0]               bit_onehot;
	logic [WORD_W-1:0]               alloc_word;
	logic                            fin_go;

	function automatic logic [WORD_W-1:0] below_mask(logic [XW-1:0] wbase,
							 logic [XW-1:0] limit);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int b = 0; b < WORD_W; b++) begin
			m[b] = (wbase + XW'(b)) < limit;
		end
		return m;
	endfunction

	bpa_find_first #(.W(NWORDS)) u_flag_ff (
		.vec   (~full_q),
		.found (flag_found),
		.idx   (flag_idx)
	);

	bpa_find_first #(.W(WORD_W)) u_bit_ff (
		.vec   (~rdata_q),
		.found (bit_found),
		.idx   (bit_idx)
	);

	always_comb begin
		pages_raw = mem_bytes_q >> PS_LOG;
		if (pages_raw > MEMB_W'(MAX_PAGES)) begin
			pages_sat = CNT_W'(MAX_PAGES);
		end else begin
			pages_sat = CNT_W'(pages_raw);
		end
		map_bytes = ({1'b0, pages_sat} + (CNT_W + 1)'(bpa_pkg::MAP_ROUND))
			>> bpa_pkg::BYTE_BITS_LOG;
		map_sum = SUM_W'(map_bytes) + SUM_W'(PAGE_SIZE - 1);
		map_pg  = map_sum >> PS_LOG;
		if (map_pg > SUM_W'(pages_sat)) begin
			map_pages = pages_sat;
		end else begin
			map_pages = CNT_W'(map_pg);
		end

		free_off  = addr_q - base_q;
		free_pidx = free_off >> PS_LOG;
		free_bad  = (addr_q == '0) || (addr_q < base_q)
			|| !(CMP_W'(free_pidx) < CMP_W'(total_q));

		sweep_base = XW'({wcnt_q, {WORD_LOG{1'b0}}});
		sweep_word = below_mask(sweep_base, XW'(map_q))
			| ~below_mask(sweep_base, XW'(total_q));

		if (op_q == bpa_pkg::OP_ALLOC) begin
			bit_onehot = WORD_W'(1) << bit_idx;
		end else begin
			bit_onehot = WORD_W'(1) << pg_q[WORD_LOG-1:0];
		end
		alloc_word = rdata_q | bit_onehot;

		mem_we    = 1'b0;
		mem_waddr = pg_q[IDX_EXT_W-1:WORD_LOG];
		mem_wdata = alloc_word;
		if (state_q == S_INIT) begin
			mem_we    = 1'b1;
			mem_waddr = wcnt_q;
			mem_wdata = sweep_word;
		end else if (state_q == S_MOD) begin
			if (op_q == bpa_pkg::OP_ALLOC) begin
				mem_we = 1'b1;
			end else if ((rdata_q & bit_onehot) != '0) begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q & ~bit_onehot;
			end
		end

		fin_go = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == S_READ) begin
			rdata_q <= mem[pg_q[IDX_EXT_W-1:WORD_LOG]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mem_bytes_q <= '0;
			base_cfg_q  <= '0;
			base_q      <= '0;
			total_q     <= '0;
			free_q      <= '0;
			map_q       <= '0;
			full_q      <= '1;
			wcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_wr_index)
					bpa_pkg::REG_MEMORY_BYTES: mem_bytes_q <= cfg_wr_data[MEMB_W-1:0];
					bpa_pkg::REG_BASE_ADDRESS: base_cfg_q  <= cfg_wr_data;
					default: ;
				endcase
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (op_q == bpa_pkg::OP_INIT) begin
						total_q <= pages_sat;
						map_q   <= map_pages;
						free_q  <= pages_sat - map_pages;
						base_q  <= ADDR_BITS'(base_cfg_q);
						wcnt_q  <= '0;
						state_q <= S_INIT;
					end else if (op_q == bpa_pkg::OP_ALLOC) begin
						state_q <= flag_found ? S_READ : S_FIN;
					end else if (op_q == bpa_pkg::OP_FREE) begin
						state_q <= free_bad ? S_FIN : S_READ;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_INIT: begin
					full_q[wcnt_q] <= &sweep_word;
					if (wcnt_q == WIDX_W'(NWORDS - 1)) begin
						state_q <= S_FIN;
					end else begin
						wcnt_q <= wcnt_q + WIDX_W'(1);
					end
				end
				S_READ: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (op_q == bpa_pkg::OP_ALLOC) begin
						full_q[pg_q[IDX_EXT_W-1:WORD_LOG]] <= &alloc_word;
						if (free_q != '0) begin
							free_q <= free_q - CNT_W'(1);
						end
					end else if ((rdata_q & bit_onehot) != '0) begin
						full_q[pg_q[IDX_EXT_W-1:WORD_LOG]] <= 1'b0;
						free_q <= free_q + CNT_W'(1);
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= opcode;
			addr_q <= page_address;
		end
		if (state_q == S_DEC) begin
			if (op_q == bpa_pkg::OP_INIT) begin
				st_q <= bpa_pkg::ST_DONE;
			end else if (op_q == bpa_pkg::OP_ALLOC) begin
				pg_q <= {flag_idx, {WORD_LOG{1'b0}}};
				st_q <= flag_found ? bpa_pkg::ST_DONE : bpa_pkg::ST_OOM;
			end else if (op_q == bpa_pkg::OP_FREE) begin
				pg_q <= IDX_EXT_W'(free_pidx);
				st_q <= free_bad ? bpa_pkg::ST_IGNORED : bpa_pkg::ST_DONE;
			end else begin
				st_q <= bpa_pkg::ST_IGNORED;
			end
		end
		if (state_q == S_MOD) begin
			if (op_q == bpa_pkg::OP_ALLOC) begin
				pg_q[WORD_LOG-1:0] <= bit_idx;
			end else if ((rdata_q & bit_onehot) == '0) begin
				st_q <= bpa_pkg::ST_IGNORED;
			end
		end
		if (fin_go) begin
			status_q      <= st_q;
			pages_free_q  <= free_q;
			pages_total_q <= total_q;
			if ((op_q == bpa_pkg::OP_ALLOC) && (st_q == bpa_pkg::ST_DONE)) begin
				alloc_address_q <= base_q + (ADDR_BITS'(pg_q) << PS_LOG);
			end else begin
				alloc_address_q <= '0;
			end
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign alloc_address = alloc_address_q;
	assign pages_free    = pages_free_q;
	assign pages_total   = pages_total_q;

	a_free_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= total_q)
		else $error("free page count exceeds total page count");

	a_alloc_bit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD) && (op_q == bpa_pkg::OP_ALLOC) |-> bit_found)
		else $error("allocation read a word that has no free page");

	a_accept_to_dec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> (state_q == S_DEC))
		else $error("accepted item did not enter decode");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside the finish state");

endmodule

`default_nettype wire

/* dv/tb_bitmap_page_allocator_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_page_allocator_unit: init, allocate and free requests
// against a page-map ledger that predicts every reply. Depends on bpa_pkg and the RTL.
`default_nettype none

module tb_bitmap_page_allocator_unit;

	localparam int PAGE = bpa_pkg::PAGE_SIZE_DEF;
	localparam int MAXPG = bpa_pkg::MAX_PAGES_DEF;
	localparam int AW = bpa_pkg::ADDR_BITS_DEF;
	localparam int OPW = bpa_pkg::OP_W;
	localparam int STW = bpa_pkg::STATUS_W;
	localparam int MBW = bpa_pkg::MEMB_W;
	localparam int CIW = bpa_pkg::CFG_IDX_W;
	localparam int CDW = bpa_pkg::CFG_DATA_W;
	localparam int CNT_W = $clog2(MAXPG + 1);
	localparam int NWORDS = (MAXPG + 63) / 64;
	localparam int SETTLE = NWORDS + 8;
	localparam int DIRECTED_N = 25;
	localparam int RANDOM_N = 900;
	localparam int LIMIT = 400000;
	localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [STW-1:0]   status;
		logic [AW-1:0]    addr;
		logic [CNT_W-1:0] free_n;
		logic [CNT_W-1:0] total_n;
	} reply_t;

	class page_ledger;
		bit page_used[MAXPG];
		logic [CNT_W-1:0] total_pg;
		logic [CNT_W-1:0] free_pg;
		logic [AW-1:0] base_q;
		logic [AW-1:0] reg_base;
		logic [MBW-1:0] reg_mem;
		reply_t replies_due[$];
		int errors, n_init, n_alloc, n_oom, n_free, n_ign, n_other;

		function new();
			total_pg = '0;
			free_pg = '0;
			base_q = '0;
			reg_base = '0;
			reg_mem = '0;
			errors = 0;
			n_init = 0;
			n_alloc = 0;
			n_oom = 0;
			n_free = 0;
			n_ign = 0;
			n_other = 0;
		endfunction

		function void write_reg(logic [CIW-1:0] idx, logic [CDW-1:0] data);
			if (idx == bpa_pkg::REG_MEMORY_BYTES) begin
				reg_mem = data[MBW-1:0];
			end else begin
				reg_base = data[AW-1:0];
			end
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		function logic [AW-1:0] used_page_addr();
			int picks[$];
			int i;
			for (i = 0; i < int'(total_pg); i++) begin
				if (page_used[i]) begin
					picks.push_back(i);
				end
			end
			if (picks.size() == 0) begin
				return base_q + AW'($urandom_range(0, 3) * PAGE);
			end
			return base_q + AW'(picks[$urandom_range(0, picks.size() - 1)] * PAGE);
		endfunction

		function void apply_request(logic [OPW-1:0] op, logic [AW-1:0] addr);
			reply_t e;
			int pg, mp, i;
			logic [AW-1:0] idx;
			e = '0;
			if (op == bpa_pkg::OP_INIT) begin
				pg = int'(reg_mem) / PAGE;
				if (pg > MAXPG) begin
					pg = MAXPG;
				end
				mp = ((pg + 7) / 8 + PAGE - 1) / PAGE;
				if (mp > pg) begin
					mp = pg;
				end
				for (i = 0; i < MAXPG; i++) begin
					page_used[i] = (i < mp);
				end
				total_pg = CNT_W'(pg);
				free_pg = CNT_W'(pg - mp);
				base_q = reg_base;
				e.status = bpa_pkg::ST_DONE;
				n_init++;
			end else if (op == bpa_pkg::OP_ALLOC) begin
				e.status = bpa_pkg::ST_OOM;
				for (i = 0; i < int'(total_pg) && e.status == bpa_pkg::ST_OOM; i++) begin
					if (!page_used[i]) begin
						page_used[i] = 1'b1;
						if (free_pg != '0) begin
							free_pg = free_pg - CNT_W'(1);
						end
						e.addr = base_q + AW'(i * PAGE);
						e.status = bpa_pkg::ST_DONE;
					end
				end
				n_alloc++;
				if (e.status == bpa_pkg::ST_OOM) begin
					n_oom++;
				end
			end else if (op == bpa_pkg::OP_FREE) begin
				e.status = bpa_pkg::ST_IGNORED;
				if (addr != '0 && addr >= base_q) begin
					idx = (addr - base_q) / AW'(PAGE);
					if (idx < AW'(total_pg)) begin
						i = int'(idx);
						if (page_used[i]) begin
							page_used[i] = 1'b0;
							free_pg = free_pg + CNT_W'(1);
							e.status = bpa_pkg::ST_DONE;
						end
					end
				end
				n_free++;
				if (e.status == bpa_pkg::ST_IGNORED) begin
					n_ign++;
				end
			end else begin
				e.status = bpa_pkg::ST_IGNORED;
				n_other++;
			end
			e.free_n = free_pg;
			e.total_n = total_pg;
			replies_due.push_back(e);
		endfunction

		function void compare_field(string label, logic [AW-1:0] want, logic [AW-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %h, actual %h",
					$time, label, want, got);
				errors++;
			end
		endfunction

		function void match_reply(reply_t got);
			reply_t e;
			if (replies_due.size() == 0) begin
				$display("%0t: result with nothing expected: expected none, actual %h",
					$time, got);
				errors++;
			end else begin
				e = replies_due.pop_front();
				compare_field("status", AW'(e.status), AW'(got.status));
				compare_field("alloc_address", e.addr, got.addr);
				compare_field("pages_free", AW'(e.free_n), AW'(got.free_n));
				compare_field("pages_total", AW'(e.total_n), AW'(got.total_n));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CIW-1:0] cfg_wr_index;
	logic [CDW-1:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	logic [OPW-1:0] opcode;
	logic [AW-1:0] page_address;
	logic out_valid;
	logic out_ready;
	logic [STW-1:0] status;
	logic [AW-1:0] alloc_address;
	logic [CNT_W-1:0] pages_free;
	logic [CNT_W-1:0] pages_total;

	page_ledger ledger = new();
	int gap_pct = 0;
	int stall_pct = 0;
	int n_sent = 0;
	int n_settings = 0;

	bitmap_page_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_index(cfg_wr_index),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.page_address(page_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.alloc_address(alloc_address),
		.pages_free(pages_free),
		.pages_total(pages_total)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("Run exceeded %0d cycles with %0d results outstanding.",
			LIMIT, ledger.pending());
		$display("tb_bitmap_page_allocator_unit NOT OK");
		$finish;
	end

	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			ledger.match_reply({status, alloc_address, pages_free, pages_total});
		end
	end

	function automatic logic [AW-1:0] rand48();
		return AW'({$urandom, $urandom});
	endfunction

	function automatic logic [AW-1:0] free_target();
		logic [AW-1:0] a, off;
		int k;
		off = $urandom_range(0, 1) ? AW'($urandom_range(0, PAGE - 1)) : '0;
		k = $urandom_range(0, 9);
		if (k < 5) begin
			a = ledger.used_page_addr() + off;
		end else if (k == 5) begin
			a = '0;
		end else if (k == 6) begin
			a = (ledger.base_q > AW'(1))
				? rand48() % (ledger.base_q - AW'(1)) + AW'(1) : rand48();
		end else if (k == 7) begin
			a = ledger.base_q + AW'((int'(ledger.total_pg) + $urandom_range(0, 2)) * PAGE) + off;
		end else if (k == 8) begin
			a = rand48();
		end else begin
			a = ledger.base_q + off
				+ AW'((int'($urandom_range(0, MAXPG - 1)) % (int'(ledger.total_pg) + 1)) * PAGE);
		end
		return a;
	endfunction

	task automatic send_request(input logic [OPW-1:0] op, input logic [AW-1:0] addr);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		page_address = addr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ledger.apply_request(op, addr);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain(input int extra);
		in_valid = 1'b0;
		while (ledger.pending() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] data);
		cfg_wr_en = 1'b1;
		cfg_wr_index = idx;
		cfg_wr_data = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		ledger.write_reg(idx, data);
	endtask

	task automatic apply_settings(input logic [MBW-1:0] mem, input logic [AW-1:0] base);
		drain(SETTLE);
		if ($urandom_range(0, 1)) begin
			write_reg(bpa_pkg::REG_MEMORY_BYTES, CDW'(mem));
			write_reg(bpa_pkg::REG_BASE_ADDRESS, CDW'(base));
		end else begin
			write_reg(bpa_pkg::REG_BASE_ADDRESS, CDW'(base));
			write_reg(bpa_pkg::REG_MEMORY_BYTES, CDW'(mem));
		end
		n_settings++;
	endtask

	task automatic random_phase(input int n);
		int i, r;
		send_request(bpa_pkg::OP_INIT, rand48());
		i = 1;
		while (i < n) begin
			r = $urandom_range(0, 99);
			if (r >= 97) begin
				drain(1);
			end else begin
				if (r < 46) begin
					send_request(bpa_pkg::OP_ALLOC, rand48());
				end else if (r < 88) begin
					send_request(bpa_pkg::OP_FREE, free_target());
				end else if (r < 93) begin
					send_request(bpa_pkg::OP_INIT, rand48());
				end else begin
					send_request(OP_UNUSED, rand48());
				end
				i++;
			end
		end
	endtask

	initial begin
		logic [MBW-1:0] mem;
		logic [AW-1:0] base;
		int k;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_index = '0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		opcode = bpa_pkg::OP_INIT;
		page_address = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Before any init the allocator manages no pages at all.
		send_request(bpa_pkg::OP_ALLOC, '0);
		send_request(bpa_pkg::OP_FREE, '0);
		send_request(bpa_pkg::OP_FREE, '1);
		send_request(OP_UNUSED, 48'h5A5A_A5A5_5A5A);
		send_request(bpa_pkg::OP_INIT, '0);
		send_request(bpa_pkg::OP_ALLOC, '0);

		base = 48'h0012_3456_7000;
		apply_settings(MBW'(5 * PAGE + 123), base);
		send_request(bpa_pkg::OP_INIT, '0);
		repeat (5) send_request(bpa_pkg::OP_ALLOC, '0);
		send_request(bpa_pkg::OP_FREE, base);
		send_request(bpa_pkg::OP_FREE, base);
		send_request(bpa_pkg::OP_FREE, base + AW'(2 * PAGE + 'h7FF));
		send_request(bpa_pkg::OP_FREE, base - AW'(1));
		send_request(bpa_pkg::OP_FREE, base + AW'(5 * PAGE));
		send_request(bpa_pkg::OP_ALLOC, '0);
		send_request(OP_UNUSED, '0);

		// Too much memory with a base at the top of the address space.
		apply_settings('1, 48'hFFFF_FFFF_F000);
		send_request(bpa_pkg::OP_INIT, '0);
		send_request(bpa_pkg::OP_ALLOC, '1);
		send_request(bpa_pkg::OP_ALLOC, '0);
		send_request(bpa_pkg::OP_FREE, AW'(PAGE));

		apply_settings(MBW'(PAGE), '0);
		send_request(bpa_pkg::OP_INIT, '0);
		send_request(bpa_pkg::OP_ALLOC, '0);

		while (n_sent < DIRECTED_N + RANDOM_N) begin
			if (n_sent > DIRECTED_N + RANDOM_N - 150) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				k = $urandom_range(0, 2);
				gap_pct = (k == 0) ? 0 : (k == 1) ? 8 : 25;
				k = $urandom_range(0, 2);
				stall_pct = (k == 0) ? 0 : (k == 1) ? 8 : 25;
			end
			k = $urandom_range(0, 9);
			case (k)
				0: mem = '0;
				1: mem = '1;
				2: mem = MBW'(MAXPG * PAGE);
				3: mem = MBW'($urandom);
				default: mem = MBW'($urandom_range(1, 48) * PAGE + $urandom_range(0, PAGE - 1));
			endcase
			k = $urandom_range(0, 5);
			case (k)
				0: base = '0;
				1: base = '1;
				2: base = '1 - AW'($urandom_range(1, 8) * PAGE - 1);
				3: base = rand48() & ~AW'(PAGE - 1);
				default: base = rand48();
			endcase
			apply_settings(mem, base);
			random_phase($urandom_range(30, 80));
		end

		drain(SETTLE);
		ledger.errors += ledger.pending();
		$display("Covered %0d items under %0d register settings: %0d init,",
			n_sent, n_settings, ledger.n_init);
		$display("%0d allocate (%0d out of memory), %0d free (%0d ignored), %0d unused opcode.",
			ledger.n_alloc, ledger.n_oom, ledger.n_free, ledger.n_ign, ledger.n_other);
		if (ledger.errors == 0) begin
			$display("tb_bitmap_page_allocator_unit OK");
		end else begin
			$display("tb_bitmap_page_allocator_unit NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
sv/bpa_pkg.sv
sv/bpa_find_first.sv
sv/bitmap_page_allocator_unit.sv
dv/tb_bitmap_page_allocator_unit.sv
